// ===== sv/csme_pkg.sv =====
package csme_pkg;

  localparam int DefMaxElements = 8192;
  localparam int DefMaxModulus  = 65536;

  localparam int ElemW  = 16;
  localparam int QueryW = 32;
  localparam int SumW   = 33;

  localparam logic [SumW-1:0] InfSum = {SumW{1'b1}};

  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef struct packed {
    logic              start;
    logic [QueryW-1:0] dividend;
    logic [ElemW-1:0]  divisor;
  } div_req_t;

endpackage

// ===== sv/csme_div.sv =====
module csme_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  csme_pkg::div_req_t                req,
  output logic                              done,
  output logic [csme_pkg::ElemW-1:0]        rem
);
  import csme_pkg::*;

  localparam int CntW = $clog2(QueryW);

  logic [QueryW-1:0] dvd_r, dvd_nxt;
  logic [ElemW-1:0]  dvs_r, dvs_nxt;
  logic [ElemW-1:0]  rem_r, rem_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ElemW:0]    trial;
  logic [ElemW:0]    diff;

  assign trial = {rem_r, dvd_r[QueryW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[QueryW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[ElemW-1:0];
      end else begin
        rem_nxt = trial[ElemW-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(QueryW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== sv/coin_sum_membership_engine.sv =====
// Coin-sum membership engine. A load beat (req_type 0) appends a positive element
// and tracks the smallest element m; a query beat (req_type 1) returns one beat
// telling whether query_value is a sum of loaded elements with repetition. Loads
// return straight to idle, except a load not below m after the table is built, which
// folds the element in by walking its g residue cycles, g being gcd(element, m).
// A query on a built table runs the 32-step shared remainder unit, then a table read.
// The first query after a new smallest element rebuilds the m-entry least-sum table:
// an init sweep, then a residue walk for each stored element, all through one table
// port pair. Not ready while busy.
module coin_sum_membership_engine #(
  parameter int MAX_ELEMENTS = csme_pkg::DefMaxElements,
  parameter int MAX_MODULUS  = csme_pkg::DefMaxModulus
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [csme_pkg::ElemW-1:0]    in_element_value,
  input  logic [csme_pkg::QueryW-1:0]   in_query_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_representable
);
  import csme_pkg::*;

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int AW = $clog2(MAX_MODULUS);

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_INIT      = 16'h0002,
    S_ELEM_RD   = 16'h0004,
    S_ELEM_WAIT = 16'h0008,
    S_DSTART    = 16'h0010,
    S_DWAIT     = 16'h0020,
    S_CYC_RD    = 16'h0040,
    S_CYC_LD    = 16'h0080,
    S_WALK_RD   = 16'h0100,
    S_WALK_UPD  = 16'h0200,
    S_CYC_END   = 16'h0400,
    S_QSTART    = 16'h0800,
    S_QWAIT     = 16'h1000,
    S_QRD       = 16'h2000,
    S_QCMP      = 16'h4000,
    S_RESP      = 16'h8000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [ElemW-1:0]  m_r, m_nxt;
  logic              built_r, built_nxt;
  logic              build_r, build_nxt;
  logic [ElemW-1:0]  a_r, a_nxt;
  logic [ElemW-1:0]  step_r, step_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [ElemW-1:0]  i_r, i_nxt;
  logic [ElemW-1:0]  r_r, r_nxt;
  logic [ElemW-1:0]  g_r, g_nxt;
  logic [ElemW-1:0]  res_r, res_nxt;
  logic [ElemW-1:0]  nres_r, nres_nxt;
  logic [SumW-1:0]   cur_r, cur_nxt;
  logic              ret_r, ret_nxt;
  logic [QueryW-1:0] k_r, k_nxt;
  logic              ans_r, ans_nxt;
  logic              ov_r, ov_nxt;
  logic              orep_r, orep_nxt;

  logic [ElemW-1:0]  store_mem [MAX_ELEMENTS];
  logic [ElemW-1:0]  store_q;
  logic              store_we;

  logic [SumW-1:0]   tbl_mem [MAX_MODULUS];
  logic [SumW-1:0]   tbl_q;
  logic [AW-1:0]     tbl_raddr;
  logic [AW-1:0]     tbl_waddr;
  logic [SumW-1:0]   tbl_wdata;
  logic              tbl_we;

  div_req_t          dreq;
  logic              ddone;
  logic [ElemW-1:0]  drem;

  logic              in_acc;
  logic              load_ok;
  logic [ElemW:0]    nsum;
  logic [ElemW-1:0]  nres;
  logic [SumW:0]     cand;

  csme_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .done  (ddone),
    .rem   (drem)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_ok  = (in_element_value != '0)
                 && (32'(in_element_value) <= 32'(MAX_MODULUS))
                 && (cnt_r < CW'(MAX_ELEMENTS));

  assign nsum = {1'b0, res_r} + {1'b0, step_r};
  assign nres = (nsum >= {1'b0, m_r}) ? ElemW'(nsum - {1'b0, m_r}) : nsum[ElemW-1:0];
  assign cand = {1'b0, cur_r} + (SumW+1)'(a_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    m_nxt     = m_r;
    built_nxt = built_r;
    build_nxt = build_r;
    a_nxt     = a_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    i_nxt     = i_r;
    r_nxt     = r_r;
    g_nxt     = g_r;
    res_nxt   = res_r;
    nres_nxt  = nres_r;
    cur_nxt   = cur_r;
    ret_nxt   = ret_r;
    k_nxt     = k_r;
    ans_nxt   = ans_r;
    ov_nxt    = ov_r;
    orep_nxt  = orep_r;
    store_we  = 1'b0;
    tbl_we    = 1'b0;
    tbl_waddr = AW'(nres_r);
    tbl_wdata = cur_r;
    tbl_raddr = AW'(r_r);
    dreq      = '{start: 1'b0, dividend: QueryW'(a_r), divisor: m_r};

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == ReqLoad) begin
            if (load_ok) begin
              store_we = 1'b1;
              cnt_nxt  = cnt_r + 1'b1;
              if (cnt_r == '0 || in_element_value < m_r) begin
                m_nxt     = in_element_value;
                built_nxt = 1'b0;
              end else if (built_r) begin
                a_nxt     = in_element_value;
                build_nxt = 1'b0;
                state_nxt = S_DSTART;
              end
            end
          end else begin
            k_nxt = in_query_value;
            if (cnt_r == '0) begin
              ans_nxt   = 1'b0;
              state_nxt = S_RESP;
            end else if (!built_r) begin
              build_nxt = 1'b1;
              i_nxt     = '0;
              state_nxt = S_INIT;
            end else begin
              state_nxt = S_QSTART;
            end
          end
        end
      end
      S_INIT: begin
        tbl_we    = 1'b1;
        tbl_waddr = AW'(i_r);
        tbl_wdata = (i_r == '0) ? '0 : InfSum;
        i_nxt     = i_r + 1'b1;
        if (i_r == m_r - 1'b1) begin
          idx_nxt   = '0;
          state_nxt = S_ELEM_RD;
        end
      end
      S_ELEM_RD: begin
        state_nxt = S_ELEM_WAIT;
      end
      S_ELEM_WAIT: begin
        a_nxt     = store_q;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        dreq.start = 1'b1;
        state_nxt  = S_DWAIT;
      end
      S_DWAIT: begin
        if (ddone) begin
          step_nxt  = drem;
          r_nxt     = '0;
          g_nxt     = m_r;
          state_nxt = S_CYC_RD;
        end
      end
      S_CYC_RD: begin
        tbl_raddr = AW'(r_r);
        state_nxt = S_CYC_LD;
      end
      S_CYC_LD: begin
        cur_nxt   = tbl_q;
        res_nxt   = r_r;
        ret_nxt   = 1'b0;
        state_nxt = S_WALK_RD;
      end
      S_WALK_RD: begin
        tbl_raddr = AW'(nres);
        nres_nxt  = nres;
        state_nxt = S_WALK_UPD;
      end
      S_WALK_UPD: begin
        if (cur_r != InfSum && cand < {1'b0, tbl_q}) begin
          tbl_we    = 1'b1;
          tbl_wdata = cand[SumW-1:0];
          cur_nxt   = cand[SumW-1:0];
        end else begin
          cur_nxt = tbl_q;
        end
        res_nxt = nres_r;
        if (r_r == '0 && nres_r != '0 && nres_r < g_r) begin
          g_nxt = nres_r;
        end
        state_nxt = S_WALK_RD;
        if (nres_r == r_r) begin
          ret_nxt = 1'b1;
          if (ret_r) begin
            state_nxt = S_CYC_END;
          end
        end
      end
      S_CYC_END: begin
        if (r_r + 1'b1 < g_r) begin
          r_nxt     = r_r + 1'b1;
          state_nxt = S_CYC_RD;
        end else if (build_r) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 < cnt_r) begin
            state_nxt = S_ELEM_RD;
          end else begin
            built_nxt = 1'b1;
            state_nxt = S_QSTART;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_QSTART: begin
        dreq      = '{start: 1'b1, dividend: k_r, divisor: m_r};
        state_nxt = S_QWAIT;
      end
      S_QWAIT: begin
        if (ddone) begin
          state_nxt = S_QRD;
        end
      end
      S_QRD: begin
        tbl_raddr = AW'(drem);
        state_nxt = S_QCMP;
      end
      S_QCMP: begin
        ans_nxt   = (tbl_q <= {1'b0, k_r});
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          orep_nxt  = ans_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[cnt_r[EW-1:0]] <= in_element_value;
    end
    store_q <= store_mem[idx_r[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    i_r    <= i_nxt;
    r_r    <= r_nxt;
    g_r    <= g_nxt;
    res_r  <= res_nxt;
    nres_r <= nres_nxt;
    cur_r  <= cur_nxt;
    ret_r  <= ret_nxt;
    k_r    <= k_nxt;
    ans_r  <= ans_nxt;
    orep_r <= orep_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      m_r     <= '1;
      built_r <= 1'b0;
      build_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      m_r     <= m_nxt;
      built_r <= built_nxt;
      build_r <= build_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_representable = orep_r;

endmodule

// ===== sv/csme_checker.sv =====
module csme_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_req_type,
  input logic out_valid,
  input logic out_ready,
  input logic out_representable
);
  import csme_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_representable))
    else $error("stalled result beat changed");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == ReqLoad) |=> !$rose(out_valid))
    else $error("load beat produced a result");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == ReqQuery) |=> !in_ready)
    else $error("ready right after query beat");

endmodule

bind coin_sum_membership_engine csme_checker u_csme_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_req_type       (in_req_type),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_representable (out_representable)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import csme_pkg::*;

  localparam int          StoreDepth = 8192;
  localparam int          ModBound   = 65536;
  localparam longint      CycleLimit = 8000000;
  localparam longint unsigned Unreached = 64'h1_FFFF_FFFF;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_req_type = ReqLoad;
  logic [ElemW-1:0]  in_element_value = '0;
  logic [QueryW-1:0] in_query_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_representable;

  int unsigned     elems [StoreDepth];
  int unsigned     elem_cnt = 0;
  int unsigned     min_elem = 16'hFFFF;
  longint unsigned least_sum [ModBound];
  bit              sums_ready = 0;
  bit              answers_q [$];
  int              errors = 0;
  longint          cyc = 0;
  bit              no_idle = 0;
  int              out_hold = 0;

  coin_sum_membership_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_element_value(in_element_value),
    .in_query_value(in_query_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_representable(out_representable)
  );

  always #5 clk = ~clk;

  function automatic int unsigned gcd_of(int unsigned a, int unsigned b);
    int unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic void relax_by(int unsigned a);
    int unsigned m, stp, g, len, res, nres;
    longint unsigned cur, cand;
    m = min_elem;
    if (m == 0 || m > ModBound || a == 0) return;
    stp = a % m;
    g = gcd_of(m, a);
    len = m / g;
    for (int unsigned r = 0; r < g; r++) begin
      res = r;
      cur = least_sum[r];
      for (int unsigned j = 0; j < 2 * len; j++) begin
        nres = res + stp;
        if (nres >= m) nres -= m;
        if (cur != Unreached) begin
          cand = cur + a;
          if (cand < least_sum[nres]) least_sum[nres] = cand;
        end
        cur = least_sum[nres];
        res = nres;
      end
    end
  endfunction

  function automatic void rebuild_sums();
    for (int unsigned i = 0; i < min_elem && i < ModBound; i++)
      least_sum[i] = (i == 0) ? 0 : Unreached;
    for (int unsigned i = 0; i < elem_cnt; i++) relax_by(elems[i]);
    sums_ready = 1;
  endfunction

  function automatic void predict_beat(logic req, int unsigned v, longint unsigned k);
    if (req == ReqLoad) begin
      if (v == 0 || v > ModBound || elem_cnt >= StoreDepth) return;
      elems[elem_cnt] = v;
      elem_cnt++;
      if (elem_cnt == 1 || v < min_elem) begin
        min_elem = v;
        sums_ready = 0;
      end else if (sums_ready) begin
        relax_by(v);
      end
    end else if (elem_cnt == 0) begin
      answers_q.push_back(1'b0);
    end else begin
      if (!sums_ready) rebuild_sums();
      answers_q.push_back(least_sum[k % min_elem] <= k);
    end
  endfunction

  task automatic send_beat(logic req, int unsigned v, int unsigned k);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_element_value <= v[ElemW-1:0];
    in_query_value   <= k;
    do @(posedge clk); while (!in_ready);
    predict_beat(req, v[ElemW-1:0], k);
  endtask

  task automatic load(int unsigned v);
    send_beat(ReqLoad, v, $urandom);
  endtask

  task automatic query(int unsigned k);
    send_beat(ReqQuery, $urandom, k);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (answers_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_empty_set();
    query(0);
    query(32'hFFFF_FFFF);
    load(0);
    query(5);
  endtask

  task automatic test_widest_element();
    load(16'hFFFF);
    query(0);
    query(16'hFFFF);
    query(16'hFFFE);
    query(32'h0001_FFFE);
    query(32'hFFFF_FFFF);
    query(32'hFFFF_0000);
  endtask

  task automatic test_small_set();
    load(60);
    load(97);
    query(97);
    query(157);
    query(59);
    load(131);
    load(16'h8000);
    query(188);
    query(1000);
    drain();
    load(40);
    query(137);
    query(32'h8000_0000);
  endtask

  task automatic test_random_mix();
    int unsigned v;
    for (int i = 0; i < 800; i++) begin
      no_idle = (i >= 100 && i < 180);
      if (i == 400) drain();
      if (i == 200 || i == 450 || i == 650) begin
        load(min_elem - $urandom_range(4, 9));
      end else if ($urandom_range(0, 99) < 55) begin
        case ($urandom_range(0, 9))
          0:       v = 0;
          1, 2, 3: v = $urandom_range(min_elem, min_elem * 4);
          default: v = $urandom_range(min_elem, 16'hFFFF);
        endcase
        load(v);
      end else begin
        query(($urandom_range(0, 1) == 0) ? $urandom_range(0, 3000) : $urandom);
      end
    end
    no_idle = 0;
  endtask

  task automatic test_store_full();
    drain();
    load(2);
    while (elem_cnt < StoreDepth) load($urandom_range(2, 16'hFFFF));
    load(3);
    load(1);
    query(1);
    query(0);
    query(32'hFFFF_FFFF);
  endtask

  always @(negedge clk) begin
    if (out_hold > 0 && !no_idle) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (answers_q.size() == 0) begin
        $error("unexpected beat: representable %0b", out_representable);
        errors++;
      end else begin
        if (out_representable !== answers_q[0]) begin
          $error("representable: expected %0b actual %0b",
                 answers_q[0], out_representable);
          errors++;
        end
        void'(answers_q.pop_front());
      end
      out_hold <= $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < ModBound; i++) least_sum[i] = (i == 0) ? 0 : Unreached;
    test_empty_set();
    test_widest_element();
    test_small_set();
    test_random_mix();
    test_store_full();
    @(negedge clk);
    in_valid <= 1'b0;
    drain();
    if (errors == 0 && answers_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== coin_sum_membership_engine.f =====
sv/csme_pkg.sv
sv/csme_div.sv
sv/coin_sum_membership_engine.sv
sv/csme_checker.sv
tb/sv/tb_top.sv
